// ===== rtl/core/hsf_pkg.sv =====
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants of the hotkey sequence filter: hold store
// sizing, result kinds, configuration register indexes and the entry
// format of the queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package hsf_pkg;

    // Hold store sizing.
    localparam int HOLD_DEPTH = 4;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Field widths.
    localparam int CODE_W = 8;
    localparam int KEY_W  = 7;
    localparam int KIND_W = 2;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_FWD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREV = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MENU = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODIFIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREV     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU     = 2'd3;

    // Reset values of the key codes.
    localparam logic [KEY_W-1:0] RST_MODIFIER = 7'h38;
    localparam logic [KEY_W-1:0] RST_PREV     = 7'h02;
    localparam logic [KEY_W-1:0] RST_NEXT     = 7'h03;
    localparam logic [KEY_W-1:0] RST_MENU     = 7'h29;

    // Key codes as seen by the matcher.
    typedef struct packed {
        logic [KEY_W-1:0] modifier;
        logic [KEY_W-1:0] prev;
        logic [KEY_W-1:0] next;
        logic [KEY_W-1:0] menu;
    } t_cfg;

    // One queued result.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/core/hsf_front.sv =====
// ----------------------------------------------------------------------------
// hsf_front
// Accepts scancodes, runs the sequence matcher, keeps the hold store and
// issues one queue entry per cycle while the queue is not full, for replays and console actions.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hsf_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    input  wire logic [hsf_pkg::CODE_W-1:0] i_scancode,
    output logic                            o_stall,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output hsf_pkg::t_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPLAY,
        S_ACTION
    } t_state;

    typedef enum logic [2:0] {
        M_START,
        M_MOD,
        M_PREV_DN,
        M_NEXT_DN,
        M_MENU_DN,
        M_PREV_UP,
        M_NEXT_UP,
        M_MENU_UP
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic [hsf_pkg::CNT_W-1:0]  r_count, n_count;
    logic [hsf_pkg::IDX_W-1:0]  r_idx,   n_idx;
    logic [hsf_pkg::KIND_W-1:0] r_kind,  n_kind;
    logic [hsf_pkg::CODE_W-1:0] r_held [hsf_pkg::HOLD_DEPTH];

    logic accept;
    logic room;
    logic store;
    logic replay_last;
    logic [hsf_pkg::CODE_W-1:0] mod_dn, mod_up, prev_dn, prev_up;
    logic [hsf_pkg::CODE_W-1:0] next_dn, next_up, menu_dn, menu_up;
    logic m_adv;
    logic m_done;
    t_mode m_mode;
    logic [hsf_pkg::KIND_W-1:0] m_kind;

    assign accept = i_valid && !o_stall;
    assign room   = r_count < hsf_pkg::CNT_W'(hsf_pkg::HOLD_DEPTH);
    assign store  = accept && room;

    // Full scancodes of each key, press and release.
    assign mod_dn  = {1'b0, i_cfg.modifier};
    assign mod_up  = {1'b1, i_cfg.modifier};
    assign prev_dn = {1'b0, i_cfg.prev};
    assign prev_up = {1'b1, i_cfg.prev};
    assign next_dn = {1'b0, i_cfg.next};
    assign next_up = {1'b1, i_cfg.next};
    assign menu_dn = {1'b0, i_cfg.menu};
    assign menu_up = {1'b1, i_cfg.menu};

    // Classify the incoming code against the current match step.
    always_comb begin
        m_adv  = 1'b0;
        m_done = 1'b0;
        m_mode = M_START;
        m_kind = hsf_pkg::KIND_FWD;
        unique case (r_mode)
            M_START: begin
                if (i_scancode == mod_dn) begin
                    m_adv  = 1'b1;
                    m_mode = M_MOD;
                end
            end
            M_MOD: begin
                priority if (i_scancode == prev_dn) begin
                    m_adv  = 1'b1;
                    m_mode = M_PREV_DN;
                end else if (i_scancode == next_dn) begin
                    m_adv  = 1'b1;
                    m_mode = M_NEXT_DN;
                end else if (i_scancode == menu_dn) begin
                    m_adv  = 1'b1;
                    m_mode = M_MENU_DN;
                end
            end
            M_PREV_DN: begin
                if (i_scancode == prev_up) begin
                    m_adv  = 1'b1;
                    m_mode = M_PREV_UP;
                end
            end
            M_NEXT_DN: begin
                if (i_scancode == next_up) begin
                    m_adv  = 1'b1;
                    m_mode = M_NEXT_UP;
                end
            end
            M_MENU_DN: begin
                if (i_scancode == menu_up) begin
                    m_adv  = 1'b1;
                    m_mode = M_MENU_UP;
                end
            end
            M_PREV_UP: begin
                m_done = (i_scancode == mod_up);
                m_kind = hsf_pkg::KIND_PREV;
            end
            M_NEXT_UP: begin
                m_done = (i_scancode == mod_up);
                m_kind = hsf_pkg::KIND_NEXT;
            end
            M_MENU_UP: begin
                m_done = (i_scancode == mod_up);
                m_kind = hsf_pkg::KIND_MENU;
            end
            default: ;
        endcase
    end

    assign replay_last = (hsf_pkg::CNT_W'(r_idx) + hsf_pkg::CNT_W'(1)) == r_count;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_count = r_count;
        n_idx   = r_idx;
        n_kind  = r_kind;
        o_push  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = room ? r_count + hsf_pkg::CNT_W'(1) : r_count;
                    priority if (m_adv) begin
                        n_mode = m_mode;
                    end else if (m_done) begin
                        n_mode  = M_START;
                        n_count = '0;
                        n_kind  = m_kind;
                        n_state = S_ACTION;
                    end else begin
                        n_mode  = M_START;
                        n_idx   = '0;
                        n_state = S_REPLAY;
                    end
                end
            end
            S_REPLAY: begin
                o_cmd.kind = hsf_pkg::KIND_FWD;
                o_cmd.code = r_held[r_idx];
                o_cmd.last = replay_last;
                if (!i_q_full) begin
                    o_push = 1'b1;
                    n_idx  = r_idx + hsf_pkg::IDX_W'(1);
                    if (replay_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ACTION: begin
                o_cmd.kind = r_kind;
                o_cmd.code = '0;
                o_cmd.last = 1'b1;
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers and hold store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_START;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
        r_kind <= n_kind;
        if (store) begin
            r_held[r_count[hsf_pkg::IDX_W-1:0]] <= i_scancode;
        end
    end

    // New codes are taken only while no replay or action is being issued.
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

`default_nettype wire

// ===== rtl/core/hsf_queue.sv =====
// ----------------------------------------------------------------------------
// hsf_queue
// Short first-in first-out queue of results between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hsf_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output hsf_pkg::t_cmd      o_cmd,
    output hsf_pkg::t_q_status o_status
);

    hsf_pkg::t_cmd r_mem [hsf_pkg::QUEUE_DEPTH];
    logic [hsf_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [hsf_pkg::QCNT_W-1:0] r_fill;
    logic do_push, do_pop;

    assign o_status.full  = r_fill == hsf_pkg::QCNT_W'(hsf_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_fill == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + hsf_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + hsf_pkg::QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + hsf_pkg::QCNT_W'(1);
                2'b01:   r_fill <= r_fill - hsf_pkg::QCNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hsf_back.sv =====
// ----------------------------------------------------------------------------
// hsf_back
// Takes results from the queue, formats them and holds them in the output
// register until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire hsf_pkg::t_cmd              i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [hsf_pkg::KIND_W-1:0]      o_result_kind,
    output logic [hsf_pkg::CODE_W-1:0]      o_code_out,
    output logic                            o_last
);

    logic r_valid;
    logic [hsf_pkg::KIND_W-1:0] r_kind;
    logic [hsf_pkg::CODE_W-1:0] r_code;
    logic r_last;

    // Load a new result when the output register is empty or being drained.
    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_kind <= i_cmd.kind;
            r_code <= (i_cmd.kind == hsf_pkg::KIND_FWD) ? i_cmd.code : '0;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_code_out    = r_code;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/hotkey_sequence_filter_core.sv =====
// ----------------------------------------------------------------------------
// hotkey_sequence_filter_core
// Scancode filter that turns a modifier plus prev, next or menu key sequence
// into a console action and forwards every other scancode unchanged.
// ----------------------------------------------------------------------------
// Flow: a scancode that extends a partial match is taken and the next one
// may follow straight away. A completed sequence occupies the front while it
// accepts the final code and then issues the action. A mismatch occupies it
// while it accepts the code and then replays every held code in order. The
// front sequencer issues one result per cycle into a two-entry queue while
// the queue is not full; the back drains that queue into the output
// register at one transfer per cycle while the receiver does not stall.
// Once a stalling receiver has let the queue fill, the front waits for as
// long as the queue stays full. The user must write key codes through the
// configuration port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module hotkey_sequence_filter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hsf_pkg::KEY_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [hsf_pkg::CODE_W-1:0]    i_scancode,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [hsf_pkg::KIND_W-1:0]         o_result_kind,
    output logic [hsf_pkg::CODE_W-1:0]         o_code_out,
    output logic                               o_last
);

    hsf_pkg::t_cfg      r_cfg;
    hsf_pkg::t_q_status q_status;
    hsf_pkg::t_cmd      push_cmd;
    hsf_pkg::t_cmd      head_cmd;
    logic               push;
    logic               pop;

    // Key code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modifier <= hsf_pkg::RST_MODIFIER;
            r_cfg.prev     <= hsf_pkg::RST_PREV;
            r_cfg.next     <= hsf_pkg::RST_NEXT;
            r_cfg.menu     <= hsf_pkg::RST_MENU;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsf_pkg::CFG_MODIFIER: r_cfg.modifier <= i_cfg_data;
                hsf_pkg::CFG_PREV:     r_cfg.prev     <= i_cfg_data;
                hsf_pkg::CFG_NEXT:     r_cfg.next     <= i_cfg_data;
                hsf_pkg::CFG_MENU:     r_cfg.menu     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: matcher, hold store and result sequencer.
    hsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_scancode (i_scancode),
        .o_stall    (o_stall),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Queue between front and back.
    hsf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Back: output register.
    hsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_status.empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_code_out    (o_code_out),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hsf_checker.sv =====
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks on the result channel of the hotkey sequence filter.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [hsf_pkg::KIND_W-1:0] o_result_kind,
    input wire logic [hsf_pkg::CODE_W-1:0] o_code_out,
    input wire logic                       o_last
);

    // Reset empties the output register.
    a_reset_clears_valid : assert property (
        @(posedge i_clk) !i_rst_n |=> !o_valid
    ) else $error("result valid after reset");

    // A stalled result holds until the transfer.
    a_stalled_result_holds : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind)
            && $stable(o_code_out) && $stable(o_last)
    ) else $error("stalled result changed");

    // A console action is always the single, final result with no code.
    a_action_is_final : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind != hsf_pkg::KIND_FWD) |-> o_last && (o_code_out == '0)
    ) else $error("console action not final or carries a code");

endmodule

bind hotkey_sequence_filter_core hsf_checker u_hsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_kind (o_result_kind),
    .o_code_out    (o_code_out),
    .o_last        (o_last)
);

`default_nettype wire
